### rtl/core/mspdf_pkg.sv
// Shared types and constants for the MSP v1 response deframer.
// No dependencies; used by every module under rtl/core.
package mspdf_pkg;

   localparam int BYTE_W          = 8;
   localparam int LEN_W           = 7;
   localparam int POS_W           = 6;
   localparam int MAX_PAYLOAD_DEF = 64;

   // Frame queue: two slots, each owning one payload bank.
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = 1;

   localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;  // '$'
   localparam logic [BYTE_W-1:0] CH_M      = 8'h4D;  // 'M'
   localparam logic [BYTE_W-1:0] CH_GT     = 8'h3E;  // '>'
   localparam logic [BYTE_W-1:0] CH_BANG   = 8'h21;  // '!'

   // Frame descriptor handed from the parser to the replay side.
   typedef struct packed {
      logic [BYTE_W-1:0] cmd;
      logic [LEN_W-1:0]  len;
      logic              err;
   } desc_type;

   typedef struct packed {
      logic     valid;
      desc_type desc;
   } desc_push_type;

   // Payload buffer write port; the bank comes from the queue write pointer.
   typedef struct packed {
      logic              en;
      logic [POS_W-1:0]  pos;
      logic [BYTE_W-1:0] data;
   } buf_wr_type;

   typedef struct packed {
      logic               empty;
      logic               full;
      logic [Q_PTR_W-1:0] wr_ptr;
      logic [Q_PTR_W-1:0] rd_ptr;
   } q_status_type;

endpackage

### rtl/core/mspdf_front.sv
// Byte parser: preamble hunt, header, payload capture and checksum check.
// Depends on mspdf_pkg; feeds mspdf_queue and the buffer in mspdf_back.
module mspdf_front #(
   parameter int MAX_PAYLOAD = mspdf_pkg::MAX_PAYLOAD_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          take,
   input  logic [mspdf_pkg::BYTE_W-1:0]  rx_byte,
   output mspdf_pkg::buf_wr_type         buf_wr,
   output mspdf_pkg::desc_push_type      push
);

   typedef enum logic [6:0] {
      PH_IDLE    = 7'b0000001,
      PH_HDR_M   = 7'b0000010,
      PH_DIR     = 7'b0000100,
      PH_SIZE    = 7'b0001000,
      PH_CMD     = 7'b0010000,
      PH_PAYLOAD = 7'b0100000,
      PH_CHECK   = 7'b1000000
   } phase_type;

   localparam logic [mspdf_pkg::BYTE_W-1:0] MAX_B = mspdf_pkg::BYTE_W'(MAX_PAYLOAD);

   phase_type                        phase_ff, phase_in;
   logic [mspdf_pkg::LEN_W-1:0]      count_ff, count_in;
   logic [mspdf_pkg::BYTE_W-1:0]     xor_ff, xor_in;
   logic [mspdf_pkg::LEN_W-1:0]      len_ff, len_in;
   logic [mspdf_pkg::BYTE_W-1:0]     cmd_ff, cmd_in;
   logic                             err_ff, err_in;

   always_comb begin
      phase_in         = phase_ff;
      count_in         = count_ff;
      xor_in           = xor_ff;
      len_in           = len_ff;
      cmd_in           = cmd_ff;
      err_in           = err_ff;
      buf_wr.en        = 1'b0;
      buf_wr.pos       = count_ff[mspdf_pkg::POS_W-1:0];
      buf_wr.data      = rx_byte;
      push.valid       = 1'b0;
      push.desc.cmd    = cmd_ff;
      push.desc.len    = len_ff;
      push.desc.err    = err_ff;
      if (take) begin
         case (phase_ff)
            PH_HDR_M: begin
               phase_in = (rx_byte == mspdf_pkg::CH_M) ? PH_DIR : PH_IDLE;
            end
            PH_DIR: begin
               err_in   = (rx_byte == mspdf_pkg::CH_BANG);
               phase_in = (rx_byte == mspdf_pkg::CH_GT || rx_byte == mspdf_pkg::CH_BANG)
                          ? PH_SIZE : PH_IDLE;
            end
            PH_SIZE: begin
               xor_in   = rx_byte;
               count_in = '0;
               if (rx_byte > MAX_B) begin
                  phase_in = PH_IDLE;
               end else begin
                  len_in   = rx_byte[mspdf_pkg::LEN_W-1:0];
                  phase_in = PH_CMD;
               end
            end
            PH_CMD: begin
               cmd_in   = rx_byte;
               xor_in   = xor_ff ^ rx_byte;
               phase_in = (len_ff != '0) ? PH_PAYLOAD : PH_CHECK;
            end
            PH_PAYLOAD: begin
               buf_wr.en = 1'b1;
               xor_in    = xor_ff ^ rx_byte;
               count_in  = count_ff + mspdf_pkg::LEN_W'(1);
               if (count_in >= len_ff) begin
                  phase_in = PH_CHECK;
               end
            end
            PH_CHECK: begin
               phase_in   = PH_IDLE;
               push.valid = (xor_ff == rx_byte);
            end
            default: begin
               phase_in = (rx_byte == mspdf_pkg::CH_DOLLAR) ? PH_HDR_M : PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
         xor_ff   <= '0;
         len_ff   <= '0;
         cmd_ff   <= '0;
         err_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         xor_ff   <= xor_in;
         len_ff   <= len_in;
         cmd_ff   <= cmd_in;
         err_ff   <= err_in;
      end
   end

endmodule

### rtl/core/mspdf_queue.sv
// Two-slot queue of accepted frame descriptors between parser and replay.
// Depends on mspdf_pkg; slot index doubles as payload bank number.
module mspdf_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  mspdf_pkg::desc_push_type      push,
   input  logic                          pop,
   output mspdf_pkg::desc_type           head,
   output mspdf_pkg::q_status_type       status
);

   localparam int CNT_W = $clog2(mspdf_pkg::Q_DEPTH + 1);

   mspdf_pkg::desc_type                slot_ff [mspdf_pkg::Q_DEPTH];
   logic [mspdf_pkg::Q_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [mspdf_pkg::Q_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]                   count_ff, count_in;
   logic                               do_push;

   assign do_push       = push.valid && (count_ff != CNT_W'(mspdf_pkg::Q_DEPTH));
   assign head          = slot_ff[rd_ptr_ff];
   assign status.empty  = (count_ff == '0);
   assign status.full   = (count_ff == CNT_W'(mspdf_pkg::Q_DEPTH));
   assign status.wr_ptr = wr_ptr_ff;
   assign status.rd_ptr = rd_ptr_ff;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + mspdf_pkg::Q_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + mspdf_pkg::Q_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(do_push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/core/mspdf_back.sv
// Replay side: two-bank payload buffer and result sequencer with output register.
// Depends on mspdf_pkg; reads descriptors from mspdf_queue.
module mspdf_back #(
   parameter int MAX_PAYLOAD = mspdf_pkg::MAX_PAYLOAD_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mspdf_pkg::buf_wr_type               buf_wr,
   input  mspdf_pkg::q_status_type             q_status,
   input  mspdf_pkg::desc_type                 head,
   output logic                                pop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [mspdf_pkg::BYTE_W-1:0]        rsp_command_id,
   output logic [mspdf_pkg::LEN_W-1:0]         rsp_frame_length,
   output logic                                rsp_error_reply,
   output logic                                rsp_has_data,
   output logic [mspdf_pkg::BYTE_W-1:0]        rsp_data_byte,
   output logic [mspdf_pkg::POS_W-1:0]         rsp_byte_position,
   output logic                                rsp_last_of_frame
);

   localparam int DEPTH = mspdf_pkg::Q_DEPTH * MAX_PAYLOAD;
   localparam int AW    = $clog2(DEPTH);

   typedef enum logic [2:0] {
      B_IDLE = 3'b001,
      B_READ = 3'b010,
      B_SHOW = 3'b100
   } bstate_type;

   logic [mspdf_pkg::BYTE_W-1:0]  payload_mem [DEPTH];
   logic [mspdf_pkg::BYTE_W-1:0]  rd_data_ff;
   bstate_type                    state_ff, state_in;
   logic [mspdf_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic                          rd_en;
   logic                          last;
   logic [AW-1:0]                 wr_addr, rd_addr;

   // bank 1 sits above bank 0
   assign wr_addr = AW'(buf_wr.pos) + (q_status.wr_ptr[0] ? AW'(MAX_PAYLOAD) : AW'(0));
   assign rd_addr = AW'(pos_ff) + (q_status.rd_ptr[0] ? AW'(MAX_PAYLOAD) : AW'(0));

   always_ff @(posedge clock) begin
      if (buf_wr.en) begin
         payload_mem[wr_addr] <= buf_wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= payload_mem[rd_addr];
      end
   end

   assign last = (head.len == '0) ||
                 ({1'b0, pos_ff} + mspdf_pkg::LEN_W'(1) == head.len);

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      pop      = 1'b0;
      rd_en    = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (!q_status.empty) begin
               pos_in   = '0;
               state_in = B_READ;
            end
         end
         B_READ: begin
            rd_en    = 1'b1;
            state_in = B_SHOW;
         end
         B_SHOW: begin
            if (!rsp_stall) begin
               if (last) begin
                  pop      = 1'b1;
                  state_in = B_IDLE;
               end else begin
                  pos_in   = pos_ff + mspdf_pkg::POS_W'(1);
                  state_in = B_READ;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         pos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
      end
   end

   assign rsp_valid         = (state_ff == B_SHOW);
   assign rsp_command_id    = head.cmd;
   assign rsp_frame_length  = head.len;
   assign rsp_error_reply   = head.err;
   assign rsp_has_data      = (head.len != '0);
   assign rsp_data_byte     = rsp_has_data ? rd_data_ff : '0;
   assign rsp_byte_position = pos_ff;
   assign rsp_last_of_frame = last;

endmodule

### rtl/core/msp_v1_response_deframer.sv
// Top level of the MSP v1 response deframer: parser, frame queue, replay.
// Depends on mspdf_pkg, mspdf_front, mspdf_queue and mspdf_back.
//
//   channel | dir | ports                                        | transfer when
//   --------+-----+----------------------------------------------+----------------------
//   req     | in  | req_valid, req_stall, req_rx_byte            | valid && !stall
//   rsp     | out | rsp_valid, rsp_stall, rsp_command_id ...     | valid && !stall
//
// The parser takes one byte per cycle; it stalls only while both payload
// banks hold frames still waiting to be replayed.
// Replay reads each result from the buffer (B_READ), then shows it from the output
// register (B_SHOW) until it transfers; B_IDLE picks up each frame's descriptor.
// Synchronous active-high reset clears parser state, queue pointers and
// replay sequencer; the payload buffer is not cleared.
// A stalled result holds its payload until the transfer completes.
module msp_v1_response_deframer #(
   parameter int MAX_PAYLOAD = mspdf_pkg::MAX_PAYLOAD_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [mspdf_pkg::BYTE_W-1:0]        req_rx_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [mspdf_pkg::BYTE_W-1:0]        rsp_command_id,
   output logic [mspdf_pkg::LEN_W-1:0]         rsp_frame_length,
   output logic                                rsp_error_reply,
   output logic                                rsp_has_data,
   output logic [mspdf_pkg::BYTE_W-1:0]        rsp_data_byte,
   output logic [mspdf_pkg::POS_W-1:0]         rsp_byte_position,
   output logic                                rsp_last_of_frame
);

   mspdf_pkg::buf_wr_type      buf_wr;
   mspdf_pkg::desc_push_type   push;
   mspdf_pkg::desc_type        head;
   mspdf_pkg::q_status_type    q_status;
   logic                       pop;
   logic                       take;

   // a free bank always exists for the parser while the queue has room
   assign req_stall = q_status.full;
   assign take      = req_valid && !req_stall;

   mspdf_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .rx_byte (req_rx_byte),
      .buf_wr  (buf_wr),
      .push    (push)
   );

   mspdf_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .head   (head),
      .status (q_status)
   );

   mspdf_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
      .clock             (clock),
      .reset             (reset),
      .buf_wr            (buf_wr),
      .q_status          (q_status),
      .head              (head),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_command_id    (rsp_command_id),
      .rsp_frame_length  (rsp_frame_length),
      .rsp_error_reply   (rsp_error_reply),
      .rsp_has_data      (rsp_has_data),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_byte_position (rsp_byte_position),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

   // a result is only ever shown for a queued frame
   a_show_needs_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !q_status.empty)
      else $error("result shown with empty frame queue");

   // an accepted frame is never lost to a full queue
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !q_status.full)
      else $error("frame pushed into full queue");

   // the replay never runs past the payload, and an empty frame is one last result
   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_has_data && {1'b0, rsp_byte_position} < rsp_frame_length) ||
                    (!rsp_has_data && rsp_last_of_frame && rsp_byte_position == '0))
      else $error("replay position outside frame");

endmodule

### bench/tb.sv
// Self-checking bench for msp_v1_response_deframer: framed byte streams in, payload replay out.
// Depends on mspdf_pkg and the msp_v1_response_deframer RTL; holds its own frame predictor.

typedef enum logic [2:0] {
   HUNT_DOLLAR,
   HUNT_M,
   TAKE_DIR,
   TAKE_SIZE,
   TAKE_CMD,
   TAKE_PAYLOAD,
   TAKE_CHECK
} parse_phase_type;

// One replayed result, packed in port order so a single compare covers every field.
typedef struct packed {
   logic [mspdf_pkg::BYTE_W-1:0] cmd;
   logic [mspdf_pkg::LEN_W-1:0]  len;
   logic                         err;
   logic                         has_data;
   logic [mspdf_pkg::BYTE_W-1:0] data;
   logic [mspdf_pkg::POS_W-1:0]  pos;
   logic                         last;
} reply_type;

class frame_predictor;
   parse_phase_type              phase;
   logic [mspdf_pkg::LEN_W-1:0]  got_count;
   logic [mspdf_pkg::BYTE_W-1:0] csum;
   logic [mspdf_pkg::LEN_W-1:0]  frame_len;
   logic [mspdf_pkg::BYTE_W-1:0] cmd_held;
   logic                         err_held;
   logic [mspdf_pkg::BYTE_W-1:0] payload [64];
   reply_type                    replies_due [$];
   int                           faults;

   function new();
      phase     = HUNT_DOLLAR;
      got_count = '0;
      csum      = '0;
      frame_len = '0;
      cmd_held  = '0;
      err_held  = 1'b0;
      faults    = 0;
   endfunction

   task log_fault(string what);
      $display("FAULT: %s", what);
      faults++;
   endtask

   // Advance the parser by one accepted byte; queue the replay if the frame checks out.
   function void take_byte(logic [7:0] b);
      reply_type r;
      case (phase)
         HUNT_M: begin
            phase = (b == mspdf_pkg::CH_M) ? TAKE_DIR : HUNT_DOLLAR;
         end
         TAKE_DIR: begin
            err_held = (b == mspdf_pkg::CH_BANG);
            phase = (b == mspdf_pkg::CH_GT || b == mspdf_pkg::CH_BANG) ? TAKE_SIZE
                                                                        : HUNT_DOLLAR;
         end
         TAKE_SIZE: begin
            csum      = b;
            got_count = '0;
            if (b > mspdf_pkg::MAX_PAYLOAD_DEF) begin
               phase = HUNT_DOLLAR;   // oversized: held length and command untouched
            end else begin
               frame_len = b[6:0];
               phase     = TAKE_CMD;
            end
         end
         TAKE_CMD: begin
            cmd_held = b;
            csum     = csum ^ b;
            phase    = (frame_len != 0) ? TAKE_PAYLOAD : TAKE_CHECK;
         end
         TAKE_PAYLOAD: begin
            payload[got_count[5:0]] = b;
            csum      = csum ^ b;
            got_count = got_count + 1'b1;
            if (got_count >= frame_len) begin
               phase = TAKE_CHECK;
            end
         end
         TAKE_CHECK: begin
            phase = HUNT_DOLLAR;
            if (csum == b) begin
               r.cmd = cmd_held;
               r.len = frame_len;
               r.err = err_held;
               if (frame_len == 0) begin
                  r.has_data = 1'b0;
                  r.data     = '0;
                  r.pos      = '0;
                  r.last     = 1'b1;
                  replies_due.push_back(r);
               end else begin
                  for (int i = 0; i < frame_len; i++) begin
                     r.has_data = 1'b1;
                     r.data     = payload[i];
                     r.pos      = i[5:0];
                     r.last     = (i + 1 == frame_len);
                     replies_due.push_back(r);
                  end
               end
            end
         end
         default: begin
            phase = (b == mspdf_pkg::CH_DOLLAR) ? HUNT_M : HUNT_DOLLAR;
         end
      endcase
   endfunction

   task match_reply(reply_type got);
      reply_type want;
      if (replies_due.size() == 0) begin
         log_fault($sformatf("unexpected result cmd=%h pos=%0d", got.cmd, got.pos));
      end else begin
         want = replies_due.pop_front();
         if (got !== want) begin
            log_fault($sformatf({"got cmd=%h len=%0d err=%b has=%b data=%h pos=%0d last=%b",
                                 " / want cmd=%h len=%0d err=%b has=%b data=%h pos=%0d last=%b"},
                                got.cmd, got.len, got.err, got.has_data, got.data, got.pos,
                                got.last, want.cmd, want.len, want.err, want.has_data,
                                want.data, want.pos, want.last));
         end
      end
   endtask
endclass

module tb;

   // Cycles with no transfer on either channel before the run is abandoned.  The slowest
   // legal stretch is a full bank pair replaying under random stall.
   localparam int QUIET_LIMIT = 2000;
   localparam int ITEM_GOAL   = 420;
   localparam logic [7:0] BAD_DIR = 8'h3C;   // '<' is a request marker, not a reply

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_stall;
   logic [mspdf_pkg::BYTE_W-1:0]        req_rx_byte;
   logic                                rsp_valid;
   logic                                rsp_stall;
   logic [mspdf_pkg::BYTE_W-1:0]        rsp_command_id;
   logic [mspdf_pkg::LEN_W-1:0]         rsp_frame_length;
   logic                                rsp_error_reply;
   logic                                rsp_has_data;
   logic [mspdf_pkg::BYTE_W-1:0]        rsp_data_byte;
   logic [mspdf_pkg::POS_W-1:0]         rsp_byte_position;
   logic                                rsp_last_of_frame;

   frame_predictor board;
   int             frame_bytes;   // bytes sent as part of frame attempts
   int             quiet;
   bit             calm;          // set during the stretch with no idling on either side

   msp_v1_response_deframer DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_command_id    (rsp_command_id),
      .rsp_frame_length  (rsp_frame_length),
      .rsp_error_reply   (rsp_error_reply),
      .rsp_has_data      (rsp_has_data),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_byte_position (rsp_byte_position),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Result side: sample before the edge updates anything, check the transfer, then
   // pick the stall for the next cycle.
   always @(posedge clock) begin
      reply_type got;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         got.cmd      = rsp_command_id;
         got.len      = rsp_frame_length;
         got.err      = rsp_error_reply;
         got.has_data = rsp_has_data;
         got.data     = rsp_data_byte;
         got.pos      = rsp_byte_position;
         got.last     = rsp_last_of_frame;
         board.match_reply(got);
      end
      rsp_stall <= !calm && ($urandom_range(99) < 22);
   end

   // Watchdog: counts consecutive cycles in which neither channel moves a transfer.
   always @(posedge clock) begin
      if (reset || (req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("msp_v1_response_deframer: mismatch");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   // One byte transfer; an optional gap with valid low comes first.  Valid stays high
   // after acceptance so back-to-back bytes never see a low/high pair in one step.
   task automatic send_byte(input logic [7:0] b);
      while (!calm && $urandom_range(99) < 22) begin
         req_valid   <= 1'b0;
         req_rx_byte <= 8'($urandom);
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall !== 1'b0);
      board.take_byte(b);
   endtask

   // Whole frame with random payload; spoil flips the checksum to a wrong value.
   task automatic send_frame(input logic [7:0] dir, input logic [7:0] cmd, input int len,
                             input bit spoil);
      logic [7:0] sum;
      logic [7:0] b;
      logic [7:0] flip;
      sum = len[7:0] ^ cmd;
      send_byte(mspdf_pkg::CH_DOLLAR);
      send_byte(mspdf_pkg::CH_M);
      send_byte(dir);
      send_byte(len[7:0]);
      send_byte(cmd);
      for (int i = 0; i < len; i++) begin
         b   = 8'($urandom);
         sum = sum ^ b;
         send_byte(b);
      end
      flip = 8'($urandom_range(255, 1));
      if (spoil) begin
         sum = sum ^ flip;
      end
      send_byte(sum);
      frame_bytes += len + 6;
   endtask

   initial begin
      int         pick;
      int         len;
      logic [7:0] b;
      bit         first;
      board       = new();
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = '0;
      rsp_stall   = 1'b0;
      quiet       = 0;
      calm        = 1'b0;
      frame_bytes = 0;
      first       = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty normal and error replies at the command extremes.
      send_frame(mspdf_pkg::CH_GT, 8'h00, 0, 1'b0);
      send_frame(mspdf_pkg::CH_BANG, 8'hFF, 0, 1'b0);
      // Second '$' in place of 'M' drops back to hunting; the rest is ignored.
      send_byte(mspdf_pkg::CH_DOLLAR);
      send_byte(mspdf_pkg::CH_DOLLAR);
      send_byte(mspdf_pkg::CH_M);
      send_byte(mspdf_pkg::CH_GT);
      // Bad direction byte.
      send_byte(mspdf_pkg::CH_DOLLAR);
      send_byte(mspdf_pkg::CH_M);
      send_byte(BAD_DIR);
      // Size one above the buffer limit.
      send_byte(mspdf_pkg::CH_DOLLAR);
      send_byte(mspdf_pkg::CH_M);
      send_byte(mspdf_pkg::CH_GT);
      send_byte(8'(mspdf_pkg::MAX_PAYLOAD_DEF + 1));
      // Empty frame with a wrong checksum: silent drop.
      send_frame(mspdf_pkg::CH_BANG, 8'h5A, 0, 1'b1);

      // Random: mostly good frames of short length, a few at the limit, plus broken ones.
      while (frame_bytes < ITEM_GOAL) begin
         calm = (frame_bytes > 180 && frame_bytes < 290);
         pick = $urandom_range(99);
         if (pick < 78) begin
            if (first) begin
               len = mspdf_pkg::MAX_PAYLOAD_DEF;
            end else if ($urandom_range(99) < 85) begin
               len = $urandom_range(8, 0);
            end else if ($urandom_range(99) < 70) begin
               len = $urandom_range(mspdf_pkg::MAX_PAYLOAD_DEF - 1, 9);
            end else begin
               len = mspdf_pkg::MAX_PAYLOAD_DEF;
            end
            first = 1'b0;
            send_frame($urandom_range(1) ? mspdf_pkg::CH_BANG : mspdf_pkg::CH_GT,
                       8'($urandom), len, pick >= 70);
         end else if (pick < 84) begin
            send_byte(mspdf_pkg::CH_DOLLAR);
            send_byte(mspdf_pkg::CH_M);
            send_byte($urandom_range(1) ? mspdf_pkg::CH_BANG : mspdf_pkg::CH_GT);
            send_byte(8'($urandom_range(255, mspdf_pkg::MAX_PAYLOAD_DEF + 1)));
            frame_bytes += 4;
         end else if (pick < 89) begin
            do b = 8'($urandom); while (b == mspdf_pkg::CH_GT || b == mspdf_pkg::CH_BANG);
            send_byte(mspdf_pkg::CH_DOLLAR);
            send_byte(mspdf_pkg::CH_M);
            send_byte(b);
            frame_bytes += 3;
         end else if (pick < 93) begin
            do b = 8'($urandom); while (b == mspdf_pkg::CH_M);
            send_byte(mspdf_pkg::CH_DOLLAR);
            send_byte(b);
            frame_bytes += 2;
         end else begin
            // Line noise between frames; kept free of '$' so the next frame starts clean.
            repeat ($urandom_range(3, 1)) begin
               do b = 8'($urandom); while (b == mspdf_pkg::CH_DOLLAR);
               send_byte(b);
            end
         end
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      while (board.replies_due.size() != 0) @(posedge clock);
      // Anything still in the replay pipe would show up within this tail.
      repeat (40) @(posedge clock);
      if (board.faults == 0) begin
         $display("msp_v1_response_deframer: match");
      end else begin
         $display("msp_v1_response_deframer: mismatch");
      end
      $finish;
   end
endmodule

### sim.f
rtl/core/mspdf_pkg.sv
rtl/core/mspdf_front.sv
rtl/core/mspdf_queue.sv
rtl/core/mspdf_back.sv
rtl/core/msp_v1_response_deframer.sv
bench/tb.sv
